### rtl/core/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg: shared types and constants of the Bayer demosaic block
// Colour codes, register indexes, command control fields and the CFA lookup.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int ROW_BITS  = 13;
  localparam logic [ROW_BITS-1:0] ROW_LAST = 13'h1FFF;
  localparam int NORM_BITS = 20;
  localparam int MAG_BITS  = 17;
  localparam logic [MAG_BITS-1:0] MAG_MAX = 17'h1FFFF;
  localparam int FW_BITS   = 13;

  localparam logic [1:0] CLR_RED   = 2'd0;
  localparam logic [1:0] CLR_GREEN = 2'd1;
  localparam logic [1:0] CLR_BLUE  = 2'd2;
  localparam logic [1:0] CLR_ALT   = 2'd3;

  localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
  localparam logic [2:0] REG_CFA_PATTERN = 3'd1;
  localparam logic [2:0] REG_CLIP_RED    = 3'd2;
  localparam logic [2:0] REG_CLIP_GREEN  = 3'd3;
  localparam logic [2:0] REG_CLIP_BLUE   = 3'd4;
  localparam logic [2:0] REG_GAIN_RED    = 3'd5;
  localparam logic [2:0] REG_GAIN_GREEN  = 3'd6;
  localparam logic [2:0] REG_GAIN_BLUE   = 3'd7;

  typedef struct packed {
    logic       done;
    logic [1:0] c_ctr;
    logic [1:0] c_n;
    logic [1:0] c_e;
    logic [1:0] slot_i;
    logic [1:0] slot_n;
    logic [1:0] slot_s;
  } cmd_ctl_t;

  function automatic logic [1:0] colour_at(input logic [7:0] cfa, input logic rpar,
                                           input logic cpar);
    logic [1:0] code;
    code = cfa[{rpar, cpar, 1'b0} +: 2];
    colour_at = (code == CLR_ALT) ? CLR_GREEN : code;
  endfunction

endpackage

### rtl/core/bbd_queue.sv
// ----------------------------------------------------------------------------
// bbd_queue: two-entry command queue
// Takes up to two pixel commands at once and hands them out one at a time.
// ----------------------------------------------------------------------------
module bbd_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_n,
  input  logic [DW-1:0] din_a,
  input  logic [DW-1:0] din_b,
  input  logic          pop,
  output logic          empty,
  output logic [DW-1:0] dout
);

  logic [DW-1:0] ent0;
  logic [DW-1:0] ent1;
  logic [1:0]    count;

  assign empty = (count == 2'd0);
  assign dout  = ent0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (empty && push_n != 2'd0) begin
      count <= push_n;
    end else if (pop && !empty) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (empty && push_n != 2'd0) begin
      ent0 <= din_a;
      ent1 <= din_b;
    end else if (pop && !empty) begin
      ent0 <= ent1;
    end
  end

endmodule

### rtl/core/bbd_front.sv
// ----------------------------------------------------------------------------
// bbd_front: request intake and raster tracking
// Keeps row and column counts, writes samples to the line store and turns each
// request into zero, one or two pixel commands for the back end.
// ----------------------------------------------------------------------------
module bbd_front #(
  parameter int MAX_WIDTH   = 4096,
  parameter int SAMPLE_BITS = 17
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic                                req_type,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic [7:0]                          cfa,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      ew,
  input  logic                                q_empty,
  input  logic                                back_idle,
  output logic [1:0]                          push_n,
  output logic [$bits(bbd_pkg::cmd_ctl_t)+3*$clog2(MAX_WIDTH)-1:0] cmd_a,
  output logic [$bits(bbd_pkg::cmd_ctl_t)+3*$clog2(MAX_WIDTH)-1:0] cmd_b,
  output logic                                mem_we,
  output logic [$clog2(3*MAX_WIDTH)-1:0]      mem_waddr,
  output logic signed [SAMPLE_BITS-1:0]       mem_wdata
);
  import bbd_pkg::*;

  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int WB    = $clog2(MAX_WIDTH+1);
  localparam int AB    = $clog2(3*MAX_WIDTH);
  localparam int CMD_W = $bits(cmd_ctl_t) + 3*CB;

  logic [ROW_BITS-1:0] row_cnt, row_cnt_next;
  logic [CB-1:0]       col_cnt, col_cnt_next;
  logic [CB-1:0]       drain_col, drain_col_next;
  logic [1:0]          slot, slot_next;
  logic                accept;

  function automatic logic [1:0] dec3(input logic [1:0] s);
    dec3 = (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] s);
    inc3 = (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [CMD_W-1:0] make_cmd(input logic done, input logic [1:0] si,
                                                input logic [1:0] sn, input logic [1:0] ss,
                                                input logic [WB-1:0] j, input logic ipar,
                                                input logic [WB-1:0] w, input logic [7:0] p);
    cmd_ctl_t      ctl;
    logic [WB-1:0] jp;
    logic [WB-1:0] jn;
    ctl.done   = done;
    ctl.c_ctr  = colour_at(p, ipar, j[0]);
    ctl.c_n    = colour_at(p, ~ipar, j[0]);
    ctl.c_e    = colour_at(p, ipar, ~j[0]);
    ctl.slot_i = si;
    ctl.slot_n = sn;
    ctl.slot_s = ss;
    jp = (j == '0) ? WB'(1) : j - WB'(1);
    jn = (j == w - WB'(1)) ? w - WB'(2) : j + WB'(1);
    make_cmd = {ctl, CB'(j), CB'(jp), CB'(jn)};
  endfunction

  assign req_ready = q_empty && back_idle;
  assign accept    = req_valid && req_ready;

  always_comb begin
    logic [ROW_BITS-1:0] r;
    logic [CB-1:0]       c;
    logic [1:0]          s;
    logic [1:0]          si;
    logic [1:0]          sn;
    logic [WB-1:0]       c1;
    logic [WB-1:0]       d;
    row_cnt_next   = row_cnt;
    col_cnt_next   = col_cnt;
    drain_col_next = drain_col;
    slot_next      = slot;
    push_n         = 2'd0;
    cmd_a          = '0;
    cmd_b          = '0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = sample;
    r  = row_cnt;
    c  = col_cnt;
    s  = slot;
    si = 2'd0;
    sn = 2'd0;
    c1 = '0;
    d  = '0;
    if (accept) begin
      if (!req_type) begin
        if (drain_col != '0) begin
          r = '0;
          c = '0;
          s = 2'd0;
        end
        if (WB'(c) >= ew) begin
          c = '0;
          s = (r == ROW_LAST) ? 2'd0 : inc3(s);
          r = r + ROW_BITS'(1);
        end
        mem_we = 1'b1;
        unique case (s)
          2'd1:    mem_waddr = AB'(c) + AB'(MAX_WIDTH);
          2'd2:    mem_waddr = AB'(c) + AB'(2*MAX_WIDTH);
          default: mem_waddr = AB'(c);
        endcase
        if (r != '0) begin
          si = dec3(s);
          sn = (r == ROW_BITS'(1)) ? s : dec3(si);
          if (c != '0) begin
            push_n = 2'd1;
            cmd_a  = make_cmd(1'b0, si, sn, s, WB'(c) - WB'(1), ~r[0], ew, cfa);
          end
          if (WB'(c) == ew - WB'(1)) begin
            push_n = 2'd2;
            cmd_b  = make_cmd(1'b0, si, sn, s, ew - WB'(1), ~r[0], ew, cfa);
          end
        end
        c1 = WB'(c) + WB'(1);
        if (c1 >= ew) begin
          col_cnt_next = '0;
          slot_next    = (r == ROW_LAST) ? 2'd0 : inc3(s);
          row_cnt_next = r + ROW_BITS'(1);
        end else begin
          col_cnt_next = CB'(c1);
          slot_next    = s;
          row_cnt_next = r;
        end
        drain_col_next = '0;
      end else if (row_cnt != '0 && col_cnt == '0) begin
        si = dec3(slot);
        sn = (row_cnt == ROW_BITS'(1)) ? si : dec3(si);
        d  = (WB'(drain_col) > ew - WB'(1)) ? ew - WB'(1) : WB'(drain_col);
        if (d != '0) begin
          push_n = 2'd1;
          cmd_a  = make_cmd(1'b0, si, sn, sn, d - WB'(1), ~row_cnt[0], ew, cfa);
        end
        if (d == ew - WB'(1)) begin
          push_n         = 2'd2;
          cmd_b          = make_cmd(1'b1, si, sn, sn, ew - WB'(1), ~row_cnt[0], ew, cfa);
          row_cnt_next   = '0;
          col_cnt_next   = '0;
          drain_col_next = '0;
          slot_next      = 2'd0;
        end else begin
          drain_col_next = CB'(d + WB'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt   <= '0;
      col_cnt   <= '0;
      drain_col <= '0;
      slot      <= 2'd0;
    end else begin
      row_cnt   <= row_cnt_next;
      col_cnt   <= col_cnt_next;
      drain_col <= drain_col_next;
      slot      <= slot_next;
    end
  end

endmodule

### rtl/core/bbd_back.sv
// ----------------------------------------------------------------------------
// bbd_back: line store and pixel engine
// Fetches the 3x3 neighborhood of a command, interpolates the channels, applies
// gains on a shared multiplier, takes the root of the energy and drives results.
// ----------------------------------------------------------------------------
module bbd_back #(
  parameter int MAX_WIDTH   = 4096,
  parameter int SAMPLE_BITS = 17
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  input  logic [$bits(bbd_pkg::cmd_ctl_t)+3*$clog2(MAX_WIDTH)-1:0] q_data,
  output logic                                q_pop,
  output logic                                idle,
  input  logic                                mem_we,
  input  logic [$clog2(3*MAX_WIDTH)-1:0]      mem_waddr,
  input  logic signed [SAMPLE_BITS-1:0]       mem_wdata,
  input  logic [15:0]                         clip_red,
  input  logic [15:0]                         clip_green,
  input  logic [15:0]                         clip_blue,
  input  logic [23:0]                         gain_red,
  input  logic [23:0]                         gain_green,
  input  logic [23:0]                         gain_blue,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic [bbd_pkg::NORM_BITS-1:0]       norm_red,
  output logic [bbd_pkg::NORM_BITS-1:0]       norm_green,
  output logic [bbd_pkg::NORM_BITS-1:0]       norm_blue,
  output logic [bbd_pkg::MAG_BITS-1:0]        magnitude,
  output logic                                clip_r,
  output logic                                clip_g,
  output logic                                clip_b,
  output logic                                clip_any,
  output logic                                frame_done
);
  import bbd_pkg::*;

  localparam int S     = SAMPLE_BITS;
  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int AB    = $clog2(3*MAX_WIDTH);
  localparam int CMD_W = $bits(cmd_ctl_t) + 3*CB;
  localparam int CW    = (S > 17) ? S : 17;
  localparam int MB    = (S > 24) ? S : 24;
  localparam int PW    = (S + MB > 37) ? S + MB : 37;
  localparam int QW    = 2*S;
  localparam int XW    = (QW > 18) ? QW : 18;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_CALC = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state;

  logic signed [S-1:0] mem [3*MAX_WIDTH];
  logic signed [S-1:0] rdata;
  logic [AB-1:0]       raddr;

  cmd_ctl_t      ctl;
  logic [CB-1:0] cj, cjp, cjn;
  logic [3:0]    rd_k;
  logic [1:0]    rd_slot;
  logic [CB-1:0] rd_col;

  logic signed [S-1:0] tap [9];
  logic signed [S-1:0] ch_r, ch_g, ch_b;
  logic                cr, cg, cb;
  logic [2:0]          mul_k;
  logic [PW-1:0]       prod;
  logic [QW-1:0]       acc;
  logic [QW-1:0]       sq_x, sq_r, sq_bit;
  logic [NORM_BITS-1:0] nr, ng, nb;

  assign idle  = (state == ST_IDLE);
  assign q_pop = idle && !q_empty;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    unique case (rd_k)
      4'd0:    begin rd_slot = ctl.slot_i; rd_col = cj;  end
      4'd1:    begin rd_slot = ctl.slot_n; rd_col = cj;  end
      4'd2:    begin rd_slot = ctl.slot_s; rd_col = cj;  end
      4'd3:    begin rd_slot = ctl.slot_i; rd_col = cjp; end
      4'd4:    begin rd_slot = ctl.slot_i; rd_col = cjn; end
      4'd5:    begin rd_slot = ctl.slot_n; rd_col = cjp; end
      4'd6:    begin rd_slot = ctl.slot_n; rd_col = cjn; end
      4'd7:    begin rd_slot = ctl.slot_s; rd_col = cjp; end
      default: begin rd_slot = ctl.slot_s; rd_col = cjn; end
    endcase
    unique case (rd_slot)
      2'd1:    raddr = AB'(rd_col) + AB'(MAX_WIDTH);
      2'd2:    raddr = AB'(rd_col) + AB'(2*MAX_WIDTH);
      default: raddr = AB'(rd_col);
    endcase
  end

  function automatic logic gt(input logic signed [S-1:0] x, input logic [15:0] t);
    gt = CW'(x) > $signed(CW'(t));
  endfunction

  // Neighborhood interpolation.
  logic signed [S-1:0] p_c, p_n, p_s, p_w, p_e, p_nw, p_ne, p_sw, p_se;
  logic signed [S+1:0] sum_x, sum_d, sum_ns, sum_we;
  logic signed [S-1:0] avg_x, avg_d, avg_ns, avg_we;
  logic signed [S-1:0] calc_r, calc_g, calc_b;
  logic                calc_cr, calc_cg, calc_cb;

  always_comb begin
    p_c  = tap[0];
    p_n  = tap[1];
    p_s  = tap[2];
    p_w  = tap[3];
    p_e  = tap[4];
    p_nw = tap[5];
    p_ne = tap[6];
    p_sw = tap[7];
    p_se = tap[8];
    sum_x  = (S+2)'(p_n) + (S+2)'(p_s) + (S+2)'(p_w) + (S+2)'(p_e);
    sum_d  = (S+2)'(p_nw) + (S+2)'(p_ne) + (S+2)'(p_sw) + (S+2)'(p_se);
    sum_ns = (S+2)'(p_n) + (S+2)'(p_s);
    sum_we = (S+2)'(p_w) + (S+2)'(p_e);
    avg_x  = S'(sum_x >>> 2);
    avg_d  = S'(sum_d >>> 2);
    avg_ns = S'(sum_ns >>> 1);
    avg_we = S'(sum_we >>> 1);

    if (ctl.c_ctr == CLR_GREEN) begin
      calc_g  = p_c;
      calc_cg = gt(p_c, clip_green);
    end else begin
      calc_g  = avg_x;
      calc_cg = gt(p_n, clip_green) || gt(p_s, clip_green) ||
                gt(p_w, clip_green) || gt(p_e, clip_green);
    end

    if (ctl.c_ctr == CLR_RED) begin
      calc_r  = p_c;
      calc_cr = gt(p_c, clip_red);
    end else if (ctl.c_n == CLR_RED) begin
      calc_r  = avg_ns;
      calc_cr = gt(p_n, clip_red) || gt(p_s, clip_red);
    end else if (ctl.c_e == CLR_RED) begin
      calc_r  = avg_we;
      calc_cr = gt(p_w, clip_red) || gt(p_e, clip_red);
    end else begin
      calc_r  = avg_d;
      calc_cr = gt(p_nw, clip_red) || gt(p_ne, clip_red) ||
                gt(p_sw, clip_red) || gt(p_se, clip_red);
    end

    if (ctl.c_ctr == CLR_BLUE) begin
      calc_b  = p_c;
      calc_cb = gt(p_c, clip_blue);
    end else if (ctl.c_n == CLR_BLUE) begin
      calc_b  = avg_ns;
      calc_cb = gt(p_n, clip_blue) || gt(p_s, clip_blue);
    end else if (ctl.c_e == CLR_BLUE) begin
      calc_b  = avg_we;
      calc_cb = gt(p_w, clip_blue) || gt(p_e, clip_blue);
    end else begin
      calc_b  = avg_d;
      calc_cb = gt(p_nw, clip_blue) || gt(p_ne, clip_blue) ||
                gt(p_sw, clip_blue) || gt(p_se, clip_blue);
    end
  end

  // Shared multiplier: three gain products, then three squares.
  logic signed [S-1:0] m_v;
  logic [S-1:0]        m_a;
  logic [MB-1:0]       m_b;
  logic [S+MB-1:0]     mul_full;
  logic                c_pos;
  logic [NORM_BITS-1:0] c_norm;
  logic [QW-1:0]       sq_t;

  always_comb begin
    unique case (mul_k)
      3'd0, 3'd3: m_v = ch_r;
      3'd1, 3'd4: m_v = ch_g;
      default:    m_v = ch_b;
    endcase
    m_a = (m_v < 0) ? S'(-m_v) : S'(m_v);
    unique case (mul_k)
      3'd0:    m_b = MB'(gain_red);
      3'd1:    m_b = MB'(gain_green);
      3'd2:    m_b = MB'(gain_blue);
      default: m_b = MB'(m_a);
    endcase
    mul_full = m_a * m_b;
    unique case (mul_k)
      3'd1:    c_pos = (ch_r > 0);
      3'd2:    c_pos = (ch_g > 0);
      default: c_pos = (ch_b > 0);
    endcase
    if (!c_pos) begin
      c_norm = '0;
    end else if (|prod[PW-1:36]) begin
      c_norm = '1;
    end else begin
      c_norm = prod[35:16];
    end
    sq_t = sq_r + sq_bit;
  end

  logic [XW-1:0] mag_e;
  logic [MAG_BITS-1:0] mag_sat;

  always_comb begin
    mag_e   = XW'(sq_r);
    mag_sat = (mag_e > XW'(MAG_MAX)) ? MAG_MAX : MAG_BITS'(mag_e);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      rd_k      <= '0;
      mul_k     <= '0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            rd_k  <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          rd_k <= rd_k + 4'd1;
          if (rd_k == 4'd9) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          mul_k <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          mul_k <= mul_k + 3'd1;
          if (mul_k == 3'd6) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_bit == '0) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          {ctl, cj, cjp, cjn} <= q_data;
        end
      end
      ST_READ: begin
        if (rd_k != 4'd0) begin
          tap[rd_k - 4'd1] <= rdata;
        end
      end
      ST_CALC: begin
        ch_r <= calc_r;
        ch_g <= calc_g;
        ch_b <= calc_b;
        cr   <= calc_cr;
        cg   <= calc_cg;
        cb   <= calc_cb;
        acc  <= '0;
      end
      ST_MUL: begin
        prod <= PW'(mul_full);
        unique case (mul_k)
          3'd1:       nr <= c_norm;
          3'd2:       ng <= c_norm;
          3'd3:       nb <= c_norm;
          3'd4, 3'd5: acc <= acc + prod[QW-1:0];
          3'd6: begin
            sq_x   <= acc + prod[QW-1:0];
            sq_r   <= '0;
            sq_bit <= QW'(1) << (QW - 2);
          end
          default: begin
          end
        endcase
      end
      ST_SQRT: begin
        if (sq_bit != '0) begin
          if (sq_x >= sq_t) begin
            sq_x <= sq_x - sq_t;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
      end
      ST_OUT: begin
        if (!res_valid || res_ready) begin
          norm_red   <= nr;
          norm_green <= ng;
          norm_blue  <= nb;
          magnitude  <= mag_sat;
          clip_r     <= cr;
          clip_g     <= cg;
          clip_b     <= cb;
          clip_any   <= cr || cg || cb;
          frame_done <= ctl.done;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/bayer_bilinear_demosaic_clip_mask.sv
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_clip_mask: streaming bilinear Bayer demosaic
// Top level with the configuration registers, intake front, queue and engine.
// ----------------------------------------------------------------------------
// Raw samples enter in raster order and each pixel leaves one row later as
// gained red, green and blue, the root of the channel energy and clip flags;
// drain requests after the last row flush it and mark the frame end. A request
// is taken only when the command queue is empty and the engine is free, while a
// finished result may still wait at the output. The engine time of each result
// is set by nine reads of the single read port of the line store, six passes of
// the shared multiplier and one root bit per cycle; a request that yields two
// results holds the engine for both in turn.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_clip_mask #(
  parameter int MAX_WIDTH   = 4096,
  parameter int SAMPLE_BITS = 17
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [4:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic                           req_type,
  input  logic signed [SAMPLE_BITS-1:0]  sample,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [bbd_pkg::NORM_BITS-1:0]  norm_red,
  output logic [bbd_pkg::NORM_BITS-1:0]  norm_green,
  output logic [bbd_pkg::NORM_BITS-1:0]  norm_blue,
  output logic [bbd_pkg::MAG_BITS-1:0]   magnitude,
  output logic                           clip_r,
  output logic                           clip_g,
  output logic                           clip_b,
  output logic                           clip_any,
  output logic                           frame_done
);
  import bbd_pkg::*;

  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int WB    = $clog2(MAX_WIDTH+1);
  localparam int AB    = $clog2(3*MAX_WIDTH);
  localparam int CMD_W = $bits(cmd_ctl_t) + 3*CB;
  localparam int EXW   = (WB > FW_BITS) ? WB : FW_BITS;

  logic [FW_BITS-1:0] frame_width;
  logic [7:0]         cfa_pattern;
  logic [15:0]        clip_red, clip_green, clip_blue;
  logic [23:0]        gain_red, gain_green, gain_blue;
  logic               cfg_we;
  logic [EXW-1:0]     fw_e;
  logic [WB-1:0]      ew;

  logic [1:0]              push_n;
  logic [CMD_W-1:0]        cmd_a, cmd_b, q_data;
  logic                    q_empty, q_pop, back_idle;
  logic                    mem_we;
  logic [AB-1:0]           mem_waddr;
  logic signed [SAMPLE_BITS-1:0] mem_wdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 13'd4096;
      cfa_pattern <= 8'd148;
      clip_red    <= 16'd16302;
      clip_green  <= 16'd16302;
      clip_blue   <= 16'd16302;
      gain_red    <= 24'd65536;
      gain_green  <= 24'd65536;
      gain_blue   <= 24'd65536;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_FRAME_WIDTH: frame_width <= pwdata[FW_BITS-1:0];
        REG_CFA_PATTERN: cfa_pattern <= pwdata[7:0];
        REG_CLIP_RED:    clip_red    <= pwdata[15:0];
        REG_CLIP_GREEN:  clip_green  <= pwdata[15:0];
        REG_CLIP_BLUE:   clip_blue   <= pwdata[15:0];
        REG_GAIN_RED:    gain_red    <= pwdata[23:0];
        REG_GAIN_GREEN:  gain_green  <= pwdata[23:0];
        default:         gain_blue   <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_FRAME_WIDTH: prdata = 32'(frame_width);
      REG_CFA_PATTERN: prdata = 32'(cfa_pattern);
      REG_CLIP_RED:    prdata = 32'(clip_red);
      REG_CLIP_GREEN:  prdata = 32'(clip_green);
      REG_CLIP_BLUE:   prdata = 32'(clip_blue);
      REG_GAIN_RED:    prdata = 32'(gain_red);
      REG_GAIN_GREEN:  prdata = 32'(gain_green);
      default:         prdata = 32'(gain_blue);
    endcase
  end

  always_comb begin
    fw_e = EXW'(frame_width);
    if (fw_e < EXW'(2)) begin
      ew = WB'(2);
    end else if (fw_e > EXW'(MAX_WIDTH)) begin
      ew = WB'(MAX_WIDTH);
    end else begin
      ew = WB'(fw_e);
    end
  end

  bbd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_type (req_type),
    .sample   (sample),
    .cfa      (cfa_pattern),
    .ew       (ew),
    .q_empty  (q_empty),
    .back_idle(back_idle),
    .push_n   (push_n),
    .cmd_a    (cmd_a),
    .cmd_b    (cmd_b),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata)
  );

  bbd_queue #(
    .DW(CMD_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push_n(push_n),
    .din_a (cmd_a),
    .din_b (cmd_b),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_data)
  );

  bbd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .idle      (back_idle),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .clip_red  (clip_red),
    .clip_green(clip_green),
    .clip_blue (clip_blue),
    .gain_red  (gain_red),
    .gain_green(gain_green),
    .gain_blue (gain_blue),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .norm_red  (norm_red),
    .norm_green(norm_green),
    .norm_blue (norm_blue),
    .magnitude (magnitude),
    .clip_r    (clip_r),
    .clip_g    (clip_g),
    .clip_b    (clip_b),
    .clip_any  (clip_any),
    .frame_done(frame_done)
  );

endmodule

### tb/tb_bayer_bilinear_demosaic_clip_mask.sv
// ----------------------------------------------------------------------------
// tb_bayer_bilinear_demosaic_clip_mask: self-checking demosaic testbench
// Streams raw Bayer frames and drain requests through the block under random
// handshake gaps. A scoreboard predicts every pixel and compares it with the
// block's results in order. Register settings change between frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bayer_bilinear_demosaic_clip_mask;
  import bbd_pkg::*;

  localparam int LINE_LEN  = 4096;
  localparam int STALL_MAX = 4000;
  localparam int SETTLE    = 200;
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic [19:0] red;
    logic [19:0] green;
    logic [19:0] blue;
    logic [16:0] mag;
    logic        cr;
    logic        cg;
    logic        cb;
    logic        cany;
    logic        done;
  } pixel_out_t;

  class demosaic_scoreboard;
    int          store [3*LINE_LEN];
    int unsigned row, col, dcol;
    int unsigned width_reg, cfa, thr [3], gain [3];
    pixel_out_t  pending_q [$];
    int          mismatches;

    function void clear();
      foreach (store[k]) store[k] = 0;
      row = 0; col = 0; dcol = 0;
      width_reg = 4096; cfa = 148;
      foreach (thr[k]) thr[k] = 16302;
      foreach (gain[k]) gain[k] = 65536;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, int unsigned val);
      case (idx)
        REG_FRAME_WIDTH: width_reg = val & 32'h1FFF;
        REG_CFA_PATTERN: cfa = val & 32'hFF;
        REG_CLIP_RED:    thr[0] = val & 32'hFFFF;
        REG_CLIP_GREEN:  thr[1] = val & 32'hFFFF;
        REG_CLIP_BLUE:   thr[2] = val & 32'hFFFF;
        REG_GAIN_RED:    gain[0] = val & 32'hFFFFFF;
        REG_GAIN_GREEN:  gain[1] = val & 32'hFFFFFF;
        REG_GAIN_BLUE:   gain[2] = val & 32'hFFFFFF;
        default: ;
      endcase
    endfunction

    function int unsigned line_width();
      if (width_reg < 2) return 2;
      if (width_reg > LINE_LEN) return LINE_LEN;
      return width_reg;
    endfunction

    function logic [1:0] colour(int unsigned r, int unsigned c);
      logic [1:0] code;
      code = cfa[{r[0], c[0], 1'b0} +: 2];
      return (code == CLR_ALT) ? CLR_GREEN : code;
    endfunction

    function longint site(int unsigned r, int unsigned c);
      return store[(r % 3) * LINE_LEN + c];
    endfunction

    function logic [19:0] scaled(longint v, int unsigned g);
      longint p;
      if (v <= 0) return 0;
      p = (v * g) >>> 16;
      return (p > 1048575) ? 20'hFFFFF : p[19:0];
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b; r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint missing(logic [1:0] want, int unsigned i, int unsigned j, longint t,
                             longint n, longint s, longint w, longint e, longint nw,
                             longint ne, longint sw, longint se, output bit clip);
      if (colour(i + 1, j) == want) begin
        clip = n > t || s > t;
        return (n + s) >>> 1;
      end
      if (colour(i, j + 1) == want) begin
        clip = w > t || e > t;
        return (w + e) >>> 1;
      end
      clip = nw > t || ne > t || sw > t || se > t;
      return (nw + ne + sw + se) >>> 2;
    endfunction

    function void predict(int unsigned i, int unsigned rn, int unsigned rs, int unsigned j,
                          int unsigned w, bit done);
      int unsigned jp, jn;
      longint ctr, n, s, we, ea, nw, ne, sw, se, rv, gv, bv;
      longint t_r, t_g, t_b;
      longint unsigned sq;
      bit cr, cg, cb;
      logic [1:0] c;
      pixel_out_t o;
      t_r = thr[0]; t_g = thr[1]; t_b = thr[2];
      jp = (j == 0) ? 1 : j - 1;
      jn = (j == w - 1) ? w - 2 : j + 1;
      ctr = site(i, j); n = site(rn, j); s = site(rs, j);
      we = site(i, jp); ea = site(i, jn);
      nw = site(rn, jp); ne = site(rn, jn); sw = site(rs, jp); se = site(rs, jn);
      c = colour(i, j);
      if (c == CLR_GREEN) begin
        gv = ctr; cg = ctr > t_g;
      end else begin
        gv = (n + s + we + ea) >>> 2;
        cg = n > t_g || s > t_g || we > t_g || ea > t_g;
      end
      if (c == CLR_RED) begin
        rv = ctr; cr = ctr > t_r;
      end else begin
        rv = missing(CLR_RED, i, j, t_r, n, s, we, ea, nw, ne, sw, se, cr);
      end
      if (c == CLR_BLUE) begin
        bv = ctr; cb = ctr > t_b;
      end else begin
        bv = missing(CLR_BLUE, i, j, t_b, n, s, we, ea, nw, ne, sw, se, cb);
      end
      sq = root(rv * rv + gv * gv + bv * bv);
      o.red = scaled(rv, gain[0]);
      o.green = scaled(gv, gain[1]);
      o.blue = scaled(bv, gain[2]);
      o.mag = (sq > 131071) ? MAG_MAX : sq[16:0];
      o.cr = cr; o.cg = cg; o.cb = cb;
      o.cany = cr | cg | cb;
      o.done = done;
      pending_q.push_back(o);
    endfunction

    function void note_request(logic kind, logic signed [16:0] smp);
      int unsigned w, r, c, i, rn, d;
      w = line_width();
      if (kind == REQ_PIXEL) begin
        if (dcol != 0) begin
          row = 0; col = 0; dcol = 0;
        end
        if (col >= w) begin
          col = 0; row = (row + 1) & 32'h1FFF;
        end
        r = row; c = col;
        store[(r % 3) * LINE_LEN + c] = smp;
        if (r >= 1) begin
          i = r - 1;
          rn = (i == 0) ? r : i - 1;
          if (c >= 1) predict(i, rn, r, c - 1, w, 0);
          if (c == w - 1) predict(i, rn, r, w - 1, w, 0);
        end
        col++;
        if (col >= w) begin
          col = 0; row = (row + 1) & 32'h1FFF;
        end
      end else begin
        if (row == 0 || col != 0) return;
        i = row - 1;
        rn = (i == 0) ? i : i - 1;
        d = (dcol > w - 1) ? w - 1 : dcol;
        if (d >= 1) predict(i, rn, rn, d - 1, w, 0);
        if (d == w - 1) begin
          predict(i, rn, rn, w - 1, w, 1);
          row = 0; col = 0; dcol = 0;
        end else begin
          dcol = d + 1;
        end
      end
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t exp_px;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
        return;
      end
      exp_px = pending_q.pop_front();
      if (got !== exp_px) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: expected r=%0d g=%0d b=%0d mag=%0d clip=%b%b%b%b done=%b",
                   exp_px.red, exp_px.green, exp_px.blue, exp_px.mag, exp_px.cr,
                   exp_px.cg, exp_px.cb, exp_px.cany, exp_px.done);
          $display("          actual   r=%0d g=%0d b=%0d mag=%0d clip=%b%b%b%b done=%b",
                   got.red, got.green, got.blue, got.mag, got.cr, got.cg, got.cb,
                   got.cany, got.done);
        end
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic req_valid, req_ready, req_type;
  logic signed [16:0] sample;
  logic res_valid, res_ready;
  logic [19:0] norm_red, norm_green, norm_blue;
  logic [16:0] magnitude;
  logic clip_r, clip_g, clip_b, clip_any, frame_done;

  demosaic_scoreboard sb;
  bit send_burst, recv_burst;
  int stall_cycles;

  bayer_bilinear_demosaic_clip_mask u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type), .sample(sample),
    .res_valid(res_valid), .res_ready(res_ready), .norm_red(norm_red),
    .norm_green(norm_green), .norm_blue(norm_blue), .magnitude(magnitude),
    .clip_r(clip_r), .clip_g(clip_g), .clip_b(clip_b), .clip_any(clip_any),
    .frame_done(frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (res_valid && res_ready)) begin
      stall_cycles <= 0;
    end else if (!rst) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, val);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send(logic kind, logic signed [16:0] smp);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 40) == 0) send_burst = ~send_burst;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1; req_type <= kind; sample <= smp;
    forever begin
      @(negedge clk);
      if (req_ready) break;
    end
    @(posedge clk);
    sb.note_request(kind, smp);
  endtask

  function automatic logic signed [16:0] pick_sample();
    int unsigned t;
    case ($urandom_range(0, 3))
      0: return 17'($urandom);
      1: begin
        t = sb.thr[$urandom_range(0, 2)];
        t = t + $urandom_range(0, 4) - 2;
        return (t > 65535) ? 17'sd65535 : t[16:0];
      end
      default: return 17'($urandom_range(0, 20000));
    endcase
  endfunction

  task automatic run_frame(int unsigned w, int unsigned rows, bit abandon);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < w; c++) begin
        if (c != 0 && $urandom_range(0, 15) == 0) send(REQ_DRAIN, 17'($urandom));
        send(REQ_PIXEL, pick_sample());
      end
    end
    if (abandon) begin
      repeat ($urandom_range(1, w - 1)) send(REQ_DRAIN, 17'($urandom));
    end else begin
      repeat (w) send(REQ_DRAIN, 17'($urandom));
    end
  endtask

  task automatic random_setup(int unsigned w);
    int unsigned ext;
    ext = $urandom_range(0, 3);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_CFA_PATTERN, (ext == 0) ? 148 : $urandom_range(0, 255));
    write_reg(REG_CLIP_RED, (ext == 1) ? 0 : $urandom_range(0, 65535));
    write_reg(REG_CLIP_GREEN, (ext == 1) ? 65535 : $urandom_range(0, 30000));
    write_reg(REG_CLIP_BLUE, $urandom_range(0, 20000));
    write_reg(REG_GAIN_RED, (ext == 2) ? 24'hFFFFFF : $urandom_range(0, 24'h3FFFF));
    write_reg(REG_GAIN_GREEN, (ext == 2) ? 0 : $urandom_range(0, 24'hFFFFFF));
    write_reg(REG_GAIN_BLUE, $urandom_range(24'h8000, 24'h30000));
  endtask

  initial begin
    @(posedge clk);
    forever begin
      int gap;
      pixel_out_t got;
      gap = recv_burst ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 40) == 0) recv_burst = ~recv_burst;
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ready <= 1'b1;
      forever begin
        @(negedge clk);
        if (res_valid) break;
      end
      got = '{norm_red, norm_green, norm_blue, magnitude, clip_r, clip_g, clip_b,
              clip_any, frame_done};
      @(posedge clk);
      sb.check_result(got);
    end
  end

  initial begin
    int unsigned sent_frames;
    sb = new();
    sb.clear();
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_valid = 1'b0; req_type = REQ_PIXEL; sample = '0; res_ready = 1'b0;
    stall_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_FRAME_WIDTH, 4);
    send(REQ_DRAIN, 0);
    send(REQ_PIXEL, -17'sd65536); send(REQ_PIXEL, 17'sd65535);
    send(REQ_DRAIN, 0);
    send(REQ_PIXEL, 0); send(REQ_PIXEL, 17'sd16303);
    send(REQ_PIXEL, 17'sd16302); send(REQ_PIXEL, 17'sd65535);
    send(REQ_PIXEL, -17'sd1); send(REQ_PIXEL, 17'sd40000);
    repeat (4) send(REQ_DRAIN, 0);
    run_frame(4, 1, 0);
    run_frame(4, 2, 1);
    run_frame(4, 2, 0);
    wait_drained();

    write_reg(REG_FRAME_WIDTH, 8);
    repeat (5) send(REQ_PIXEL, pick_sample());
    wait_drained();
    write_reg(REG_FRAME_WIDTH, 4);
    run_frame(4, 1, 0);
    wait_drained();

    random_setup(1);
    run_frame(2, 3, 0);
    wait_drained();
    random_setup(0);
    run_frame(2, 2, 0);
    wait_drained();
    random_setup(8191);
    repeat (6) send(REQ_PIXEL, pick_sample());
    wait_drained();
    write_reg(REG_FRAME_WIDTH, 4);
    run_frame(4, 1, 0);
    wait_drained();

    sent_frames = 0;
    while (sent_frames < 24) begin
      int unsigned w;
      w = $urandom_range(2, 10);
      random_setup(w);
      repeat ($urandom_range(1, 3)) begin
        run_frame(w, $urandom_range(1, 4), $urandom_range(0, 5) == 0);
        sent_frames++;
      end
      run_frame(w, $urandom_range(1, 4), 0);
      sent_frames++;
      wait_drained();
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bbd_pkg.sv
rtl/core/bbd_queue.sv
rtl/core/bbd_front.sv
rtl/core/bbd_back.sv
rtl/core/bayer_bilinear_demosaic_clip_mask.sv
tb/tb_bayer_bilinear_demosaic_clip_mask.sv
